// File: hdl/indel_right_shift_calculator_defines.svh
`ifndef INDEL_RIGHT_SHIFT_CALCULATOR_DEFINES_SVH
`define INDEL_RIGHT_SHIFT_CALCULATOR_DEFINES_SVH

// same-cycle implication on the block clock, masked during reset
`define IRSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock, masked during reset
`define IRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/irsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irsc_pkg;

    localparam int REF_DEPTH_DEF  = 65536;
    localparam int MAX_ALLELE_DEF = 64;

    localparam logic [1:0] REQ_LOAD_REF = 2'd0;
    localparam logic [1:0] REQ_LOAD_ALT = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    localparam logic [1:0] KIND_DEL  = 2'd0;
    localparam logic [1:0] KIND_INS  = 2'd1;
    localparam logic [1:0] KIND_CPLX = 2'd2;

    localparam logic REG_REF_LENGTH = 1'b0;

    localparam logic [15:0] SHIFT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] pos;
        logic [6:0]  ref_len;
        logic [6:0]  alt_len;
    } query_t;

    typedef struct packed {
        logic        sat;
        logic [6:0]  alt_len;
        logic [6:0]  ref_len;
        logic [1:0]  kind;
        logic [15:0] shift;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/irsc_ref_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module irsc_ref_mem #(
    parameter int DEPTH = irsc_pkg::REF_DEPTH_DEF,
    parameter int AW    = $clog2(irsc_pkg::REF_DEPTH_DEF)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_a_addr,
    input  wire logic [AW-1:0] rd_b_addr,
    output logic      [7:0]    rd_a_data,
    output logic      [7:0]    rd_b_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

// File: hdl/irsc_alt_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module irsc_alt_mem #(
    parameter int DEPTH = irsc_pkg::MAX_ALLELE_DEF,
    parameter int AW    = $clog2(irsc_pkg::MAX_ALLELE_DEF)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/irsc_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module irsc_walker #(
    parameter int REF_DEPTH  = irsc_pkg::REF_DEPTH_DEF,
    parameter int MAX_ALLELE = irsc_pkg::MAX_ALLELE_DEF,
    parameter int AW         = $clog2(irsc_pkg::REF_DEPTH_DEF),
    parameter int AAW        = $clog2(irsc_pkg::MAX_ALLELE_DEF)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire irsc_pkg::query_t   query,
    input  wire logic [16:0]        ref_length,
    output logic                    idle,
    output logic      [AW-1:0]      ref_a_addr,
    output logic      [AW-1:0]      ref_b_addr,
    output logic      [AAW-1:0]     alt_addr,
    input  wire logic [7:0]         ref_a_data,
    input  wire logic [7:0]         ref_b_data,
    input  wire logic [7:0]         alt_data,
    input  wire logic               res_ready,
    output logic                    res_valid,
    output irsc_pkg::result_t       res
);

    localparam int PTR_W = ((AW > 17) ? AW : 17) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_SELF,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    irsc_pkg::query_t    q_reg, q_next;
    logic [1:0]          kind_reg, kind_next;
    logic [PTR_W-1:0]    len_reg, len_next;
    logic [PTR_W-1:0]    pa_reg, pa_next;
    logic [PTR_W-1:0]    pb_reg, pb_next;
    logic [6:0]          ii_reg, ii_next;
    logic                pend_reg, pend_next;
    logic [15:0]         count_reg, count_next;
    logic                res_valid_reg, res_valid_next;
    irsc_pkg::result_t   res_reg, res_next;

    logic [PTR_W-1:0] cfg_len;
    logic [PTR_W-1:0] depth_c;
    logic [15:0]      count_inc;
    logic             ins_go;
    logic             self_go;

    assign depth_c   = PTR_W'(REF_DEPTH);
    assign cfg_len   = PTR_W'(ref_length);
    assign count_inc = (count_reg == irsc_pkg::SHIFT_MAX) ? count_reg : count_reg + 16'd1;

    assign ins_go  = (ii_reg < q_reg.alt_len) && (pb_reg < len_reg)
                   && (32'(ii_reg) < 32'(MAX_ALLELE));
    assign self_go = (pa_reg < len_reg) && (pb_reg < len_reg);

    assign ref_a_addr = pa_reg[AW-1:0];
    assign ref_b_addr = pb_reg[AW-1:0];
    assign alt_addr   = AAW'(ii_reg);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        q_next         = q_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        ii_next        = ii_reg;
        pend_next      = 1'b0;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    q_next     = query;
                    count_next = 16'd0;
                    ii_next    = 7'd1;
                    len_next   = (cfg_len > depth_c) ? depth_c : cfg_len;
                    if ((query.ref_len > query.alt_len) && (query.alt_len == 7'd1)) begin
                        kind_next  = irsc_pkg::KIND_DEL;
                        pa_next    = PTR_W'(query.pos);
                        pb_next    = PTR_W'(query.pos) + PTR_W'(query.ref_len) - PTR_W'(1);
                        state_next = ST_SELF;
                    end else if ((query.ref_len == 7'd1) && (query.alt_len > 7'd1)) begin
                        kind_next  = irsc_pkg::KIND_INS;
                        pb_next    = PTR_W'(query.pos) + PTR_W'(1);
                        state_next = ST_INS;
                    end else begin
                        kind_next  = irsc_pkg::KIND_CPLX;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_INS: begin
                if (pend_reg && (alt_data != ref_b_data)) begin
                    state_next = ST_OUT;
                end else begin
                    if (pend_reg) begin
                        count_next = count_inc;
                    end
                    if (ins_go) begin
                        pb_next   = pb_reg + PTR_W'(1);
                        ii_next   = ii_reg + 7'd1;
                        pend_next = 1'b1;
                    end else if (ii_reg == q_reg.alt_len) begin
                        // every inserted base matched: carry on along the reference
                        pa_next    = PTR_W'(q_reg.pos);
                        pb_next    = PTR_W'(q_reg.pos) + PTR_W'(q_reg.alt_len) - PTR_W'(1);
                        state_next = ST_SELF;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SELF: begin
                if (pend_reg && (ref_a_data != ref_b_data)) begin
                    state_next = ST_OUT;
                end else begin
                    if (pend_reg) begin
                        count_next = count_inc;
                    end
                    if (self_go) begin
                        pa_next   = pa_reg + PTR_W'(1);
                        pb_next   = pb_reg + PTR_W'(1);
                        pend_next = 1'b1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!res_valid_reg || res_ready) begin
                    res_valid_next   = 1'b1;
                    res_next.shift   = count_reg;
                    res_next.kind    = kind_reg;
                    res_next.ref_len = q_reg.ref_len;
                    res_next.alt_len = q_reg.alt_len;
                    res_next.sat     = (count_reg == irsc_pkg::SHIFT_MAX);
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
        q_reg     <= q_next;
        kind_reg  <= kind_next;
        len_reg   <= len_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        ii_reg    <= ii_next;
        count_reg <= count_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

// File: hdl/indel_right_shift_calculator.sv
// indel right shift calculator
// s_ channel carries requests: s_tuser is the request type, loads write one base
// into the reference store or the alternate allele store, queries ask how far an
// indel at a position can move right. m_ channel returns one result per query,
// none for loads. ref_length is set through the apb port; the user must write it
// only while the block is idle, the block itself does not enforce it. a query
// compares base pairs, and an insertion may go on to walk the reference; the walk
// does one compare a cycle, set by the dual read port reference memory.
// a complex variant skips the walk. the next request is taken once the
// current query has moved its result to the output register.
// reset clears the control state and ref_length; the base stores are not cleared
// and must be loaded before they are read. when the receiver stalls the result
// waits in the output register, loads are still taken and a further query is
// taken and walked but its result waits for that register to empty.
`timescale 1ns / 1ps
`default_nettype none

module indel_right_shift_calculator #(
    parameter int REF_DEPTH  = irsc_pkg::REF_DEPTH_DEF,
    parameter int MAX_ALLELE = irsc_pkg::MAX_ALLELE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // load_index, load_base, variant_position, ref_allele_len, alt_allele_len
    input  wire logic [55:0] s_tdata,
    // req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // shift_amount, ref_len_echo, alt_len_echo, shift_saturated
    output logic      [31:0] m_tdata,
    // indel_kind
    output logic      [1:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW  = $clog2(REF_DEPTH);
    localparam int AAW = $clog2(MAX_ALLELE);

    logic [16:0]       ref_length_reg, ref_length_next;
    logic              s_accept;
    logic              cfg_wr;
    logic              walk_idle;
    logic              ref_wr;
    logic              alt_wr;
    logic              q_start;
    logic [15:0]       load_index;
    logic [7:0]        load_base;
    irsc_pkg::query_t  query;
    logic [AW-1:0]     ref_a_addr;
    logic [AW-1:0]     ref_b_addr;
    logic [AAW-1:0]    alt_addr;
    logic [7:0]        ref_a_data;
    logic [7:0]        ref_b_data;
    logic [7:0]        alt_data;
    irsc_pkg::result_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == irsc_pkg::REG_REF_LENGTH);
    assign prdata = (paddr[2] == irsc_pkg::REG_REF_LENGTH) ? {15'd0, ref_length_reg} : 32'd0;
    assign ref_length_next = cfg_wr ? pwdata[16:0] : ref_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_length_reg <= 17'd0;
        end else begin
            ref_length_reg <= ref_length_next;
        end
    end

    assign load_index    = s_tdata[15:0];
    assign load_base     = s_tdata[23:16];
    assign query.pos     = s_tdata[39:24];
    assign query.ref_len = s_tdata[46:40];
    assign query.alt_len = s_tdata[53:47];

    assign s_tready = walk_idle;
    assign s_accept = s_tvalid && s_tready;
    assign ref_wr   = s_accept && (s_tuser == irsc_pkg::REQ_LOAD_REF)
                    && (32'(load_index) < 32'(REF_DEPTH));
    assign alt_wr   = s_accept && (s_tuser == irsc_pkg::REQ_LOAD_ALT)
                    && (32'(load_index) < 32'(MAX_ALLELE));
    assign q_start  = s_accept && (s_tuser == irsc_pkg::REQ_QUERY);

    irsc_ref_mem #(
        .DEPTH (REF_DEPTH),
        .AW    (AW)
    ) u_ref_mem (
        .aclk      (aclk),
        .wr_en     (ref_wr),
        .wr_addr   (AW'(load_index)),
        .wr_data   (load_base),
        .rd_a_addr (ref_a_addr),
        .rd_b_addr (ref_b_addr),
        .rd_a_data (ref_a_data),
        .rd_b_data (ref_b_data)
    );

    irsc_alt_mem #(
        .DEPTH (MAX_ALLELE),
        .AW    (AAW)
    ) u_alt_mem (
        .aclk    (aclk),
        .wr_en   (alt_wr),
        .wr_addr (AAW'(load_index)),
        .wr_data (load_base),
        .rd_addr (alt_addr),
        .rd_data (alt_data)
    );

    irsc_walker #(
        .REF_DEPTH  (REF_DEPTH),
        .MAX_ALLELE (MAX_ALLELE),
        .AW         (AW),
        .AAW        (AAW)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (q_start),
        .query      (query),
        .ref_length (ref_length_reg),
        .idle       (walk_idle),
        .ref_a_addr (ref_a_addr),
        .ref_b_addr (ref_b_addr),
        .alt_addr   (alt_addr),
        .ref_a_data (ref_a_data),
        .ref_b_data (ref_b_data),
        .alt_data   (alt_data),
        .res_ready  (m_tready),
        .res_valid  (m_tvalid),
        .res        (res)
    );

    assign m_tdata = {1'b0, res.sat, res.alt_len, res.ref_len, res.shift};
    assign m_tuser = res.kind;

endmodule

`default_nettype wire

// File: hdl/irsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "indel_right_shift_calculator_defines.svh"

module irsc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready
);

    // a stalled result holds
    `IRSC_ASSERT_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

    // complex variants never shift
    `IRSC_ASSERT_NOW(a_cplx_zero, m_tvalid && (m_tuser == irsc_pkg::KIND_CPLX), m_tdata[15:0] == 16'd0, "complex variant with non-zero shift")

    // saturation flag agrees with the shift value
    `IRSC_ASSERT_NOW(a_sat_flag, m_tvalid, m_tdata[30] == (m_tdata[15:0] == irsc_pkg::SHIFT_MAX), "saturation flag mismatch")

    // a deletion has a single base alternate allele and a longer reference allele
    `IRSC_ASSERT_NOW(a_del_lens, m_tvalid && (m_tuser == irsc_pkg::KIND_DEL), (m_tdata[29:23] == 7'd1) && (m_tdata[22:16] > 7'd1), "deletion with wrong allele lengths")

endmodule

bind indel_right_shift_calculator irsc_checker u_irsc_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [31:0] NUC_SET       = "ACGT";
    localparam logic [7:0]  BASE_N        = 8'h4E;
    localparam logic [7:0]  BASE_A        = 8'h41;
    localparam logic [7:0]  BASE_C        = 8'h43;
    localparam logic [7:0]  BASE_T        = 8'h54;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          LONG_RUN      = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // load_index, load_base, variant_position, ref_allele_len, alt_allele_len
    logic [55:0] s_tdata  = '0;
    // req_type
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // shift_amount, ref_len_echo, alt_len_echo, shift_saturated
    logic [31:0] m_tdata;
    // indel_kind
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the block state
    logic [7:0]  ref_mem  [0:irsc_pkg::REF_DEPTH_DEF-1];
    bit          ref_seen [0:irsc_pkg::REF_DEPTH_DEF-1];
    logic [7:0]  alt_mem  [0:irsc_pkg::MAX_ALLELE_DEF-1];
    bit          alt_seen [0:irsc_pkg::MAX_ALLELE_DEF-1];
    logic [16:0] len_cfg  = '0;

    irsc_pkg::result_t pending_shifts [$];
    bit                steady        = 1'b0;
    bit                mismatch_seen = 1'b0;
    int unsigned       items_sent    = 0;

    indel_right_shift_calculator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 24);
    end

    function automatic int unsigned ref_run(input int unsigned a, input int unsigned b,
                                            input int unsigned lim, inout bit clean);
        int unsigned n;
        bit going;
        n = 0;
        going = 1'b1;
        while (going && a < lim && b < lim) begin
            if (!ref_seen[a] || !ref_seen[b]) begin
                clean = 1'b0;
                going = 1'b0;
            end else if (ref_mem[a] != ref_mem[b]) begin
                going = 1'b0;
            end else begin
                a++;
                b++;
                n++;
            end
        end
        return n;
    endfunction

    // returns 0 when the walk would touch a base that was never loaded
    function automatic bit predict_shift(input logic [15:0] pos, input logic [6:0] rl,
                                         input logic [6:0] al,
                                         output irsc_pkg::result_t res);
        int unsigned lim, count, i, j;
        bit clean, going;
        lim = (len_cfg > irsc_pkg::REF_DEPTH_DEF) ? irsc_pkg::REF_DEPTH_DEF : int'(len_cfg);
        count = 0;
        clean = 1'b1;
        res.kind = irsc_pkg::KIND_CPLX;
        if (al == 7'd1 && rl > 7'd1) begin
            res.kind = irsc_pkg::KIND_DEL;
            count = ref_run(int'(pos), int'(pos) + int'(rl) - 1, lim, clean);
        end else if (rl == 7'd1 && al > 7'd1) begin
            res.kind = irsc_pkg::KIND_INS;
            i = 1;
            j = int'(pos);
            going = 1'b1;
            while (going && i < al && j + 1 < lim && i < irsc_pkg::MAX_ALLELE_DEF) begin
                if (!alt_seen[i] || !ref_seen[j + 1]) begin
                    clean = 1'b0;
                    going = 1'b0;
                end else if (alt_mem[i] != ref_mem[j + 1]) begin
                    going = 1'b0;
                end else begin
                    i++;
                    j++;
                    count++;
                end
            end
            if (clean && i == al) begin
                count += ref_run(int'(pos), j, lim, clean);
            end
        end
        res.sat     = (count >= irsc_pkg::SHIFT_MAX);
        res.shift   = res.sat ? irsc_pkg::SHIFT_MAX : count[15:0];
        res.ref_len = rl;
        res.alt_len = al;
        return clean;
    endfunction

    function automatic logic [7:0] pick_base(input bit any_byte);
        return any_byte ? 8'($urandom) : NUC_SET[8 * $urandom_range(0, 3) +: 8];
    endfunction

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    always @(posedge aclk) begin : check_results
        irsc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_shifts.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                mismatch_seen = 1'b1;
            end else begin
                want = pending_shifts.pop_front();
                compare_field("shift_amount", want.shift, m_tdata[15:0]);
                compare_field("ref_len_echo", 16'(want.ref_len), 16'(m_tdata[22:16]));
                compare_field("alt_len_echo", 16'(want.alt_len), 16'(m_tdata[29:23]));
                compare_field("shift_saturated", 16'(want.sat), 16'(m_tdata[30]));
                compare_field("indel_kind", 16'(want.kind), 16'(m_tuser));
            end
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [55:0] payload);
        irsc_pkg::result_t expected_shift;
        while (!steady && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        case (kind)
            irsc_pkg::REQ_LOAD_REF: begin
                ref_mem[payload[15:0]]  = payload[23:16];
                ref_seen[payload[15:0]] = 1'b1;
                items_sent++;
            end
            irsc_pkg::REQ_LOAD_ALT: begin
                if (payload[15:0] < irsc_pkg::MAX_ALLELE_DEF) begin
                    alt_mem[payload[5:0]]  = payload[23:16];
                    alt_seen[payload[5:0]] = 1'b1;
                    items_sent++;
                end
            end
            irsc_pkg::REQ_QUERY: begin
                void'(predict_shift(payload[39:24], payload[46:40], payload[53:47],
                                    expected_shift));
                pending_shifts.push_back(expected_shift);
                items_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic load_ref(input logic [15:0] idx, input logic [7:0] b);
        send_request(irsc_pkg::REQ_LOAD_REF,
                     {2'b00, 7'($urandom), 7'($urandom), 16'($urandom), b, idx});
    endtask

    task automatic load_alt(input logic [15:0] idx, input logic [7:0] b);
        send_request(irsc_pkg::REQ_LOAD_ALT,
                     {2'b00, 7'($urandom), 7'($urandom), 16'($urandom), b, idx});
    endtask

    task automatic ask_shift(input logic [15:0] pos, input logic [6:0] rl, input logic [6:0] al);
        send_request(irsc_pkg::REQ_QUERY, {2'b00, al, rl, pos, 8'($urandom), 16'($urandom)});
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) == 0) begin
            send_request(REQ_UNUSED, {2'b00, 54'({$urandom, $urandom})});
        end else begin
            load_alt(16'($urandom_range(irsc_pkg::MAX_ALLELE_DEF, 65535)), 8'($urandom));
        end
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_shifts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_ref_length(input logic [16:0] value);
        s_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {irsc_pkg::REG_REF_LENGTH, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        len_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // empty reference: every walk stops at once
    task automatic test_after_reset();
        ask_shift(16'd0, 7'd2, 7'd1);
        ask_shift(16'd0, 7'd1, 7'd2);
        ask_shift(16'd0, 7'd2, 7'd2);
        send_request(REQ_UNUSED, {2'b00, 54'({$urandom, $urandom})});
        load_alt(16'd64, 8'hFF);
        load_alt(16'hFFFF, 8'h00);
        finish_phase();
    endtask

    task automatic test_short_repeats();
        string pattern = "CACACAGTTTTTAGCAGCAGTN";
        int unsigned k;
        for (k = 0; k < pattern.len(); k++) load_ref(16'(k), pattern[k]);
        for (k = 0; k < irsc_pkg::MAX_ALLELE_DEF; k++) load_alt(16'(k), 8'(k * 4 + 3));
        load_alt(16'd1, BASE_A);
        load_alt(16'd2, BASE_C);
        set_ref_length(17'(pattern.len()));
        ask_shift(16'd0, 7'd3, 7'd1);
        ask_shift(16'd7, 7'd2, 7'd1);
        ask_shift(16'd6, 7'd2, 7'd1);
        ask_shift(16'd0, 7'd1, 7'd3);
        ask_shift(16'd0, 7'd1, 7'd4);
        ask_shift(16'd1, 7'd1, 7'd2);
        ask_shift(16'd0, 7'd64, 7'd1);
        ask_shift(16'd0, 7'd1, 7'd64);
        ask_shift(16'd0, 7'd1, 7'd127);
        ask_shift(16'd0, 7'd127, 7'd1);
        ask_shift(16'd0, 7'd2, 7'd2);
        ask_shift(16'd0, 7'd1, 7'd1);
        ask_shift(16'd0, 7'd0, 7'd0);
        ask_shift(16'd0, 7'd0, 7'd5);
        ask_shift(16'd0, 7'd5, 7'd0);
        ask_shift(16'(pattern.len()), 7'd2, 7'd1);
        ask_shift(16'hFFFF, 7'd1, 7'd2);
        finish_phase();
        // length cut inside the run of t
        set_ref_length(17'd10);
        load_alt(16'd1, BASE_T);
        ask_shift(16'd7, 7'd2, 7'd1);
        ask_shift(16'd7, 7'd1, 7'd2);
        finish_phase();
    endtask

    task automatic test_random_walks(input int unsigned target);
        int unsigned first, s, n, m, k, q, qn, span, mutate, tries;
        logic [15:0] pos;
        logic [6:0]  rl, al;
        logic [7:0]  b;
        logic [7:0]  motif [0:5];
        logic [16:0] len_pick;
        bit          any_byte, ok;
        irsc_pkg::result_t scratch;
        first = items_sent;
        while (items_sent - first < target) begin
            finish_phase();
            n = $urandom_range(16, 80);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, irsc_pkg::REF_DEPTH_DEF - n)
                                            : $urandom_range(0, 200);
            case ($urandom_range(0, 5))
                0, 1: len_pick = 17'(s + n);
                2: len_pick = 17'(s + $urandom_range(1, n));
                3: len_pick = 17'(irsc_pkg::REF_DEPTH_DEF);
                4: len_pick = 17'($urandom_range(0, irsc_pkg::REF_DEPTH_DEF));
                default: len_pick = 17'($urandom_range(0, 3));
            endcase
            set_ref_length(len_pick);
            steady = ($urandom_range(0, 4) == 0);
            m = $urandom_range(1, 6);
            any_byte = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 6; k++) motif[k] = pick_base(any_byte);
            // tandem repeat with the odd substitution, closed by an N base
            for (k = 0; k + 1 < n; k++) begin
                b = motif[k % m];
                if ($urandom_range(0, 9) == 0) b = pick_base(any_byte);
                load_ref(16'(s + k), b);
                if ($urandom_range(0, 15) == 0) send_noise();
            end
            load_ref(16'(s + n - 1), BASE_N);
            qn = $urandom_range(10, 30);
            for (q = 0; q < qn; q++) begin
                ok = 1'b0;
                for (tries = 0; tries < 6 && !ok; tries++) begin
                    pos = 16'(s + $urandom_range(0, n - 1));
                    span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 63)
                                                       : m * $urandom_range(1, 3);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            rl = 7'(span + 1);
                            al = 7'd1;
                        end
                        4, 5, 6: begin
                            rl = 7'd1;
                            al = 7'(span + 1);
                            mutate = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : 0;
                            for (k = 1; k <= span; k++) begin
                                b = (pos + k < irsc_pkg::REF_DEPTH_DEF && ref_seen[pos + k])
                                    ? ref_mem[pos + k] : pick_base(any_byte);
                                load_alt(16'(k), (k == mutate) ? ~b : b);
                            end
                        end
                        7: begin
                            rl = 7'($urandom_range(2, 64));
                            al = 7'($urandom_range(2, 64));
                        end
                        8: begin
                            rl = 7'($urandom);
                            al = 7'($urandom);
                        end
                        default: begin
                            pos = 16'($urandom);
                            if ($urandom_range(0, 1) == 0) begin
                                rl = 7'd1;
                                al = 7'($urandom_range(2, 64));
                            end else begin
                                rl = 7'($urandom_range(2, 64));
                                al = 7'd1;
                            end
                        end
                    endcase
                    ok = predict_shift(pos, rl, al, scratch);
                end
                // fall back to a substitution, which reads nothing
                if (!ok) begin
                    rl = 7'd2;
                    al = 7'd2;
                end
                ask_shift(pos, rl, al);
            end
        end
        steady = 1'b0;
    endtask

    // stretch of one base: the walks run until the length cuts them off
    task automatic test_long_run();
        int unsigned k;
        finish_phase();
        set_ref_length(17'(LONG_RUN));
        steady = 1'b1;
        for (k = 0; k < LONG_RUN; k++) load_ref(16'(k), BASE_A);
        load_alt(16'd1, BASE_A);
        ask_shift(16'd0, 7'd2, 7'd1);
        ask_shift(16'd0, 7'd1, 7'd2);
        ask_shift(16'(LONG_RUN - 2), 7'd2, 7'd1);
        ask_shift(16'(LONG_RUN - 1), 7'd2, 7'd1);
        finish_phase();
        set_ref_length(17'(LONG_RUN - 1));
        ask_shift(16'd0, 7'd2, 7'd1);
        steady = 1'b0;
        finish_phase();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_short_repeats();
        test_random_walks(780);
        test_long_run();
        finish_phase();
        if (!mismatch_seen) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/irsc_pkg.sv
hdl/irsc_ref_mem.sv
hdl/irsc_alt_mem.sv
hdl/irsc_walker.sv
hdl/indel_right_shift_calculator.sv
hdl/irsc_checker.sv
bench/testbench.sv
